@@ rtl/core/prp_pkg.sv @@
// Shared constants and types for the page replacement policy block.
package prp_pkg;

  localparam int unsigned MaxPagesDefault  = 1024;
  localparam int unsigned MaxFramesDefault = 256;

  localparam int unsigned PageNumW = 10;
  localparam int unsigned PageCntW = 11;
  localparam int unsigned FrameCntW = 9;
  localparam int unsigned ModeW = 2;
  localparam int unsigned CountW = 32;

  typedef enum logic [1:0] {
    MODE_FIFO  = 2'd0,
    MODE_LRU   = 2'd1,
    MODE_CLOCK = 2'd2,
    MODE_ALT   = 2'd3
  } mode_e;

  localparam logic [1:0] RegMode     = 2'd0;
  localparam logic [1:0] RegPrepage  = 2'd1;
  localparam logic [1:0] RegPageCnt  = 2'd2;
  localparam logic [1:0] RegFrameCnt = 2'd3;

endpackage

@@ rtl/core/page_replacement_policy_top.sv @@
// Page replacement policy unit: FIFO, LRU and clock eviction with optional pre-paging.
//
// One reference per transfer, one result per reference. After reset and after every
// configuration write a clearing pass walks all MAX_PAGES page entries (one per cycle,
// plus MAX_FRAMES frame entries in parallel) while input is stalled. A bad page goes
// straight to the result; a hit reads the page entry and updates its stamp. A fault adds
// one eviction: FIFO takes the frame at the hand, LRU reads the frame table and stamp
// memory in series for every frame in use, clock steps the hand, at most F+1 steps
// (bound 2*F+1). Pre-paging searches the following pages for one not resident and,
// when a page is loaded, makes a second eviction. Page and frame memories are single-port.
// The result sits in its own output register, so the next reference is taken while
// the previous result waits; a finished reference waits only while that register
// is still full and stalled.
module page_replacement_policy_top
  import prp_pkg::*;
#(
  parameter int unsigned MAX_PAGES  = MaxPagesDefault,
  parameter int unsigned MAX_FRAMES = MaxFramesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PageNumW-1:0]  page_number_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 hit_o,
  output logic                 bad_page_o,
  output logic                 victim_valid_o,
  output logic [PageNumW-1:0]  victim_page_o,
  output logic                 prefetch_valid_o,
  output logic [PageNumW-1:0]  prefetch_page_o,
  output logic [PageNumW-1:0]  prefetch_victim_page_o,
  output logic [CountW-1:0]    fault_total_o
);

  localparam int unsigned PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned PCW = $clog2(MAX_PAGES + 1);
  localparam int unsigned FCW = $clog2(MAX_FRAMES + 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_LOOKW, S_REPL, S_FIFO, S_LRU_F, S_LRU_FW, S_LRU_S,
    S_LRU_SW, S_CLK_F, S_CLK_FW, S_CLK_P, S_CLK_PW, S_OLD, S_NEWP, S_PF_R, S_PF_RW,
    S_PF_STAMP, S_OUT
  } state_e;

  // page memory word: {use, resident, stamp}
  typedef struct packed {
    logic              use_b;
    logic              res;
    logic [CountW-1:0] stamp;
  } pent_t;

  pent_t           pmem [MAX_PAGES];
  logic [PW-1:0]   fmem [MAX_FRAMES];

  logic            pm_we, fm_we;
  logic [PW-1:0]   pm_addr, fm_wdata;
  logic [FW-1:0]   fm_addr;
  pent_t           pm_wdata, pm_rdata;
  logic [PW-1:0]   fm_rdata;

  always_ff @(posedge clk_i) begin
    if (pm_we) pmem[pm_addr] <= pm_wdata;
    pm_rdata <= pmem[pm_addr];
  end
  always_ff @(posedge clk_i) begin
    if (fm_we) fmem[fm_addr] <= fm_wdata;
    fm_rdata <= fmem[fm_addr];
  end

  // configuration
  logic [ModeW-1:0]     mode_q;
  logic                 prep_q;
  logic [PageCntW-1:0]  pcnt_q;
  logic [FrameCntW-1:0] fcnt_q;
  logic                 cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      RegMode:     prdata[ModeW-1:0] = mode_q;
      RegPrepage:  prdata[0] = prep_q;
      RegPageCnt:  prdata[PageCntW-1:0] = pcnt_q;
      RegFrameCnt: prdata[FrameCntW-1:0] = fcnt_q;
      default:     prdata = '0;
    endcase
  end

  // pages and frames in use
  logic [PCW-1:0] np;
  logic [FCW-1:0] nf;
  always_comb begin
    logic [PageCntW:0] pc;
    logic [FrameCntW:0] fc;
    pc = {1'b0, pcnt_q};
    fc = {1'b0, fcnt_q};
    if (pc == 0) pc = (PageCntW+1)'(1);
    if (pc > (PageCntW+1)'(MAX_PAGES)) np = PCW'(MAX_PAGES);
    else np = PCW'(pc);
    if (fc == 0) fc = (FrameCntW+1)'(1);
    if ((FrameCntW+1)'(fc) > (FrameCntW+1)'(MAX_FRAMES)) fc = (FrameCntW+1)'(MAX_FRAMES);
    if (32'(fc) > 32'(np)) nf = FCW'(np);
    else nf = FCW'(fc);
  end

  state_e           st_q;
  logic [PCW-1:0]   ci_q;      // clear index
  logic [PW-1:0]    p_q, q_q, cur_q, old_q;
  logic [FW-1:0]    hand_q, fr_q, best_fr_q;
  logic [PCW-1:0]   cnt_q;     // clock step count
  logic [CountW-1:0] best_q, refc_q, fltc_q;
  logic             pf_q;      // current replace is the prefetch
  logic             hit_q, bad_q, vv_q, pv_q;
  logic [PW-1:0]    vp_q, pp_q, pvp_q;
  logic             ovalid_q;

  // output register, loaded when the finished result can move out
  logic              out_load;
  logic              hit_out_q, bad_out_q, vv_out_q, pv_out_q;
  logic [PW-1:0]     vp_out_q, pp_out_q, pvp_out_q;
  logic [CountW-1:0] flt_out_q;

  assign out_load = (st_q == S_OUT) && !cfg_wr && (!ovalid_q || !out_stall_i);

  assign in_stall_o = (st_q != S_IDLE);
  assign out_valid_o = ovalid_q;
  assign hit_o = hit_out_q;
  assign bad_page_o = bad_out_q;
  assign victim_valid_o = vv_out_q;
  assign victim_page_o = PageNumW'(vp_out_q);
  assign prefetch_valid_o = pv_out_q;
  assign prefetch_page_o = PageNumW'(pp_out_q);
  assign prefetch_victim_page_o = PageNumW'(pvp_out_q);
  assign fault_total_o = flt_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      hit_out_q <= 1'b0; bad_out_q <= 1'b0; vv_out_q <= 1'b0; pv_out_q <= 1'b0;
      vp_out_q <= '0; pp_out_q <= '0; pvp_out_q <= '0; flt_out_q <= '0;
    end else if (out_load) begin
      ovalid_q <= 1'b1;
      hit_out_q <= hit_q; bad_out_q <= bad_q; vv_out_q <= vv_q; pv_out_q <= pv_q;
      vp_out_q <= vp_q; pp_out_q <= pp_q; pvp_out_q <= pvp_q; flt_out_q <= fltc_q;
    end else if (!out_stall_i) begin
      ovalid_q <= 1'b0;
    end
  end

  function automatic logic [FW-1:0] fnext(logic [FW-1:0] f, logic [FCW-1:0] n);
    logic [FCW:0] t;
    t = {1'b0, FCW'(f)} + 1'b1;
    if (t >= {1'b0, n}) return '0;
    return t[FW-1:0];
  endfunction

  function automatic logic [PW-1:0] pnext(logic [PW-1:0] p, logic [PCW-1:0] n);
    logic [PCW:0] t;
    t = {1'b0, PCW'(p)} + 1'b1;
    if (t >= {1'b0, n}) return '0;
    return t[PW-1:0];
  endfunction

  // memory port control
  always_comb begin
    pm_we = 1'b0; pm_addr = cur_q; pm_wdata = pm_rdata;
    fm_we = 1'b0; fm_addr = fr_q; fm_wdata = fm_rdata;
    case (st_q)
      S_CLEAR: begin
        pm_we = 1'b1; pm_addr = ci_q[PW-1:0];
        pm_wdata = '{use_b: 1'b0, res: (ci_q < PCW'(nf)), stamp: '0};
        if (ci_q < PCW'(MAX_FRAMES)) begin
          fm_we = 1'b1; fm_addr = ci_q[FW-1:0];
          fm_wdata = (ci_q < PCW'(nf)) ? ci_q[PW-1:0] : '0;
        end
      end
      S_IDLE: pm_addr = page_number_i[PW-1:0];
      S_LOOKW: begin
        pm_we = 1'b1; pm_addr = p_q;
        pm_wdata = pm_rdata;
        pm_wdata.stamp = refc_q;
        if (pm_rdata.res && mode_q[1]) pm_wdata.use_b = 1'b1;
      end
      S_FIFO: fm_addr = hand_q;
      S_LRU_F, S_CLK_F: fm_addr = fr_q;
      S_LRU_S, S_CLK_P: pm_addr = fm_rdata;
      S_CLK_PW: begin
        if (pm_rdata.use_b) begin
          pm_we = 1'b1; pm_addr = old_q; pm_wdata = pm_rdata; pm_wdata.use_b = 1'b0;
        end
      end
      S_OLD: begin
        pm_addr = old_q;
        pm_we = 1'b1; pm_wdata = pm_rdata; pm_wdata.res = 1'b0;
        fm_we = 1'b1; fm_addr = fr_q; fm_wdata = cur_q;
      end
      S_NEWP: pm_addr = cur_q;
      S_PF_R: pm_addr = q_q;
      S_PF_STAMP: begin
        pm_we = 1'b1; pm_addr = cur_q;
        pm_wdata = pm_rdata;
        pm_wdata.res = 1'b1;
        pm_wdata.stamp = refc_q;
        if (mode_q[1]) pm_wdata.use_b = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_FIFO; prep_q <= 1'b0;
      pcnt_q <= PageCntW'(1024); fcnt_q <= FrameCntW'(256);
      st_q <= S_CLEAR; ci_q <= '0;
      hand_q <= '0; refc_q <= '0; fltc_q <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          RegMode:     mode_q <= pwdata[ModeW-1:0];
          RegPrepage:  prep_q <= pwdata[0];
          RegPageCnt:  pcnt_q <= pwdata[PageCntW-1:0];
          RegFrameCnt: fcnt_q <= pwdata[FrameCntW-1:0];
          default: ;
        endcase
        st_q <= S_CLEAR; ci_q <= '0; hand_q <= '0; refc_q <= '0; fltc_q <= '0;
      end else begin
        case (st_q)
          S_CLEAR: begin
            if (ci_q == PCW'(MAX_PAGES - 1)) st_q <= S_IDLE;
            ci_q <= ci_q + 1'b1;
          end
          S_IDLE: begin
            if (in_valid_i) begin
              p_q <= page_number_i[PW-1:0];
              cur_q <= page_number_i[PW-1:0];
              hit_q <= 1'b0; bad_q <= 1'b0; vv_q <= 1'b0; pv_q <= 1'b0;
              vp_q <= '0; pp_q <= '0; pvp_q <= '0; pf_q <= 1'b0;
              if ({1'b0, page_number_i} >= (PageNumW+1)'(32'(np))) begin
                bad_q <= 1'b1; st_q <= S_OUT;
              end else begin
                if (refc_q != '1) refc_q <= refc_q + 1'b1;
                st_q <= S_LOOK;
              end
            end
          end
          S_LOOK: st_q <= S_LOOKW;
          S_LOOKW: begin
            if (pm_rdata.res) begin
              hit_q <= 1'b1; st_q <= S_OUT;
            end else begin
              if (fltc_q != '1) fltc_q <= fltc_q + 1'b1;
              vv_q <= 1'b1; st_q <= S_REPL;
            end
          end
          S_REPL: begin
            if (32'(hand_q) >= 32'(nf)) hand_q <= '0;
            case (mode_q)
              MODE_FIFO: st_q <= S_FIFO;
              MODE_LRU: begin
                fr_q <= '0; best_fr_q <= '0; st_q <= S_LRU_F;
              end
              default: begin
                cnt_q <= '0; st_q <= S_CLK_F;
                fr_q <= (32'(hand_q) >= 32'(nf)) ? '0 : hand_q;
              end
            endcase
          end
          S_FIFO: begin
            fr_q <= hand_q; hand_q <= fnext(hand_q, nf); st_q <= S_LRU_FW;
            best_fr_q <= hand_q;
          end
          S_LRU_F: st_q <= S_LRU_FW;
          S_LRU_FW: begin
            if (mode_q == MODE_FIFO) begin
              old_q <= fm_rdata; st_q <= S_OLD;
            end else st_q <= S_LRU_S;
          end
          S_LRU_S: st_q <= S_LRU_SW;
          S_LRU_SW: begin
            logic [FW-1:0] bf;
            bf = best_fr_q;
            if (fr_q == '0 || pm_rdata.stamp < best_q) begin
              best_q <= pm_rdata.stamp; bf = fr_q;
            end
            best_fr_q <= bf;
            // reread the frame table at the winning frame
            if (32'(fr_q) + 1 >= 32'(nf)) begin
              fr_q <= bf; st_q <= S_CLK_F;
            end else begin
              fr_q <= fr_q + 1'b1; st_q <= S_LRU_F;
            end
          end
          S_CLK_F: st_q <= S_CLK_FW;
          S_CLK_FW: begin
            old_q <= fm_rdata;
            st_q <= (mode_q == MODE_LRU) ? S_OLD : S_CLK_P;
          end
          S_CLK_P: st_q <= S_CLK_PW;
          S_CLK_PW: begin
            hand_q <= fnext(fr_q, nf);
            if (!pm_rdata.use_b || cnt_q == PCW'(2 * 32'(nf))) begin
              if (pm_rdata.use_b) fr_q <= '0;
              st_q <= pm_rdata.use_b ? S_CLK_F : S_OLD;
              if (pm_rdata.use_b) cnt_q <= '1; // loop exhausted: frame 0
            end else begin
              fr_q <= fnext(fr_q, nf); cnt_q <= cnt_q + 1'b1; st_q <= S_CLK_F;
            end
            if (cnt_q == '1) st_q <= S_OLD;
          end
          S_OLD: begin
            if (pf_q) pvp_q <= old_q; else vp_q <= old_q;
            st_q <= S_NEWP;
          end
          S_NEWP: st_q <= S_PF_STAMP;
          S_PF_STAMP: begin
            if (!pf_q && prep_q) begin
              q_q <= pnext(p_q, np); st_q <= S_PF_R;
            end else st_q <= S_OUT;
          end
          S_PF_R: begin
            if (q_q == p_q) st_q <= S_OUT;
            else st_q <= S_PF_RW;
          end
          S_PF_RW: begin
            if (!pm_rdata.res) begin
              pf_q <= 1'b1; pv_q <= 1'b1; pp_q <= q_q; cur_q <= q_q; st_q <= S_REPL;
            end else begin
              q_q <= pnext(q_q, np); st_q <= S_PF_R;
            end
          end
          S_OUT: begin
            if (out_load) st_q <= S_IDLE;
          end
          default: st_q <= S_IDLE;
        endcase
      end
    end
  end

endmodule
